// ===== design/i2cms_pkg.sv =====
package i2cms_pkg;

  // Default sizes of the payload buffer and of the register address.
  localparam int PAYLOAD_DEPTH_DEF     = 256;
  localparam int MAX_ADDRESS_BYTES_DEF = 4;

  // Result queue between the sequencer and the output channel.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PW    = 2;
  localparam int OUTQ_CW    = 3;

  // Bus status codes; the low three bits of a status are ignored.
  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RCV_ACK   = 8'h50;
  localparam logic [7:0] ST_RCV_NACK  = 8'h58;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_STATUS = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RXACK   = 3'd3,
    CMD_RXNACK  = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_RELEASE = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_WSTART = 4'd1,
    PH_WSLA   = 4'd2,
    PH_WADDR  = 4'd3,
    PH_WDATA  = 4'd4,
    PH_RSTART = 4'd5,
    PH_RSLA   = 4'd6,
    PH_RDATA  = 4'd7
  } phase_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NACK = 2'd1;
  localparam logic [1:0] ERR_BUS  = 2'd2;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [6:0]  device_address;
    logic [31:0] internal_address;
    logic [2:0]  address_bytes;
    logic [7:0]  byte_count;
    logic [7:0]  bus_status;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  // Results produced by one processed item: zero, one or two.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic res_t mk_res(cmd_t cmd, logic [7:0] tx, logic rxv, logic [7:0] rx,
                                  logic done, logic [1:0] err, logic last);
    res_t r;
    r.command    = cmd;
    r.tx_byte    = tx;
    r.rx_valid   = rxv;
    r.rx_byte    = rx;
    r.done_res   = done;
    r.error_code = err;
    r.last       = last;
    return r;
  endfunction

  function automatic logic status_is(logic [7:0] s, logic [7:0] code);
    return (s & ST_MASK) == code;
  endfunction

endpackage

// ===== design/i2c_master_transaction_sequencer_core.sv =====
// An accepted transaction is registered in the input register, processed once the result
// queue has room for two results, and its results are registered in the result queue that
// drives the output channel.
// Throughput: one input transaction per cycle while the four-entry result queue has room
// for two results; the output side drains one result per cycle while out_tready is high.
// Reset: synchronous, active low; clears the phase, transaction state and result queue.
module i2c_master_transaction_sequencer_core #(
  parameter int PAYLOAD_DEPTH     = i2cms_pkg::PAYLOAD_DEPTH_DEF,
  parameter int MAX_ADDRESS_BYTES = i2cms_pkg::MAX_ADDRESS_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // payload_index, payload_byte, device_address, internal_address, address_bytes,
  // byte_count, bus_status, bus_data; zero padded to 88 bits
  input  logic [87:0] in_tdata,
  // opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_byte, rx_valid, rx_byte, done_res, error_code; zero padded to 24 bits
  output logic [23:0] out_tdata,
  // command
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  i2cms_pkg::in_item_t in_item;
  i2cms_pkg::push_t    push;
  i2cms_pkg::res_t     out_res;
  logic                room;
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [7:0]          mem_wr_data;
  logic [AW-1:0]       mem_rd_addr;
  logic [7:0]          mem_rd_data;

  // Unpack the input transaction.
  always_comb begin
    in_item.opcode           = i2cms_pkg::opcode_t'(in_tuser);
    in_item.payload_index    = in_tdata[7:0];
    in_item.payload_byte     = in_tdata[15:8];
    in_item.device_address   = in_tdata[22:16];
    in_item.internal_address = in_tdata[54:23];
    in_item.address_bytes    = in_tdata[57:55];
    in_item.byte_count       = in_tdata[65:58];
    in_item.bus_status       = in_tdata[73:66];
    in_item.bus_data         = in_tdata[81:74];
  end

  i2cms_seq #(
    .PAYLOAD_DEPTH     (PAYLOAD_DEPTH),
    .MAX_ADDRESS_BYTES (MAX_ADDRESS_BYTES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (in_item),
    .room        (room),
    .push        (push),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  i2cms_payload_buf #(
    .DEPTH (PAYLOAD_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  i2cms_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result transaction.
  assign out_tdata = {4'd0, out_res.error_code, out_res.done_res, out_res.rx_byte,
                      out_res.rx_valid, out_res.tx_byte};
  assign out_tuser = out_res.command;
  assign out_tlast = out_res.last;

endmodule

// ===== design/i2cms_payload_buf.sv =====
module i2cms_payload_buf #(
  parameter int DEPTH = i2cms_pkg::PAYLOAD_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same slot is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/i2cms_seq.sv =====
module i2cms_seq #(
  parameter int PAYLOAD_DEPTH     = i2cms_pkg::PAYLOAD_DEPTH_DEF,
  parameter int MAX_ADDRESS_BYTES = i2cms_pkg::MAX_ADDRESS_BYTES_DEF,
  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cms_pkg::in_item_t in_item,
  input  logic                room,
  output i2cms_pkg::push_t    push,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output logic [7:0]          mem_wr_data,
  output logic [AW-1:0]       mem_rd_addr,
  input  logic [7:0]          mem_rd_data
);

  // Input register.
  i2cms_pkg::in_item_t item_r;
  logic                item_valid_r;
  logic                fire;

  // Transaction state.
  i2cms_pkg::phase_t phase_r, phase_nxt;
  logic              read_mode_r, read_mode_nxt;
  logic [6:0]        target_r, target_nxt;
  logic [31:0]       reg_addr_r, reg_addr_nxt;
  logic [2:0]        addr_left_r, addr_left_nxt;
  logic [7:0]        bytes_left_r, bytes_left_nxt;
  logic [7:0]        bptr_r, bptr_nxt;

  // Buffer slot of each 8-bit index, folded to the buffer depth.
  logic [AW-1:0] slot_lut [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_slot
    assign slot_lut[gi] = AW'(gi % PAYLOAD_DEPTH);
  end

  assign fire     = item_valid_r && room;
  assign in_ready = !item_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  // Payload buffer access: loads write, the read port follows the pointer.
  assign mem_wr_en   = fire && (item_r.opcode == i2cms_pkg::OP_LOAD);
  assign mem_wr_addr = slot_lut[item_r.payload_index];
  assign mem_wr_data = item_r.payload_byte;
  assign mem_rd_addr = slot_lut[bptr_nxt];

  // One step of the sequencer for the registered item.
  always_comb begin
    logic [7:0] s;
    logic [2:0] nab;
    logic [2:0] al_m1;
    logic [7:0] addr_byte;
    logic [7:0] bl_dec;

    phase_nxt      = phase_r;
    read_mode_nxt  = read_mode_r;
    target_nxt     = target_r;
    reg_addr_nxt   = reg_addr_r;
    addr_left_nxt  = addr_left_r;
    bytes_left_nxt = bytes_left_r;
    bptr_nxt       = bptr_r;
    push.count     = 2'd0;
    push.res0      = '0;
    push.res1      = '0;

    s         = item_r.bus_status;
    al_m1     = addr_left_r - 3'd1;
    addr_byte = reg_addr_r[{al_m1[1:0], 3'b000} +: 8];
    bl_dec    = (bytes_left_r != 8'd0) ? (bytes_left_r - 8'd1) : bytes_left_r;
    nab       = (item_r.address_bytes > 3'(MAX_ADDRESS_BYTES)) ?
                3'(MAX_ADDRESS_BYTES) : item_r.address_bytes;

    if (fire) begin
      case (item_r.opcode)
        i2cms_pkg::OP_LOAD: begin
          push.count = 2'd0;
        end
        i2cms_pkg::OP_WRITE, i2cms_pkg::OP_READ: begin
          if (phase_r == i2cms_pkg::PH_IDLE) begin
            read_mode_nxt  = (item_r.opcode == i2cms_pkg::OP_READ);
            target_nxt     = item_r.device_address;
            reg_addr_nxt   = item_r.internal_address;
            addr_left_nxt  = nab;
            bytes_left_nxt = item_r.byte_count;
            bptr_nxt       = 8'd0;
            phase_nxt      = (read_mode_nxt && nab == 3'd0) ?
                             i2cms_pkg::PH_RSTART : i2cms_pkg::PH_WSTART;
            push.count     = 2'd1;
            push.res0      = i2cms_pkg::mk_res(i2cms_pkg::CMD_START, 8'd0, 1'b0, 8'd0,
                                               1'b0, i2cms_pkg::ERR_NONE, 1'b1);
          end
        end
        default: begin
          // Bus status report; no result while idle, two on the switch to the read restart, else a single result.
          push.count = (phase_r == i2cms_pkg::PH_IDLE) ? 2'd0 : 2'd1;
          case (phase_r)
            i2cms_pkg::PH_WSTART, i2cms_pkg::PH_RSTART: begin
              if (i2cms_pkg::status_is(s, i2cms_pkg::ST_START) ||
                  i2cms_pkg::status_is(s, i2cms_pkg::ST_RSTART)) begin
                if (phase_r == i2cms_pkg::PH_RSTART) begin
                  phase_nxt = i2cms_pkg::PH_RSLA;
                  push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_SEND, {target_r, 1'b1},
                                                1'b0, 8'd0, 1'b0, i2cms_pkg::ERR_NONE, 1'b1);
                end else begin
                  phase_nxt = i2cms_pkg::PH_WSLA;
                  push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_SEND, {target_r, 1'b0},
                                                1'b0, 8'd0, 1'b0, i2cms_pkg::ERR_NONE, 1'b1);
                end
              end else begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_NONE, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_BUS, 1'b1);
              end
            end
            i2cms_pkg::PH_WSLA, i2cms_pkg::PH_WADDR, i2cms_pkg::PH_WDATA: begin
              if ((phase_r == i2cms_pkg::PH_WSLA) ?
                  i2cms_pkg::status_is(s, i2cms_pkg::ST_SLAW_ACK) :
                  i2cms_pkg::status_is(s, i2cms_pkg::ST_DATA_ACK)) begin
                // Acknowledged: address bytes, then the read restart or the payload.
                if (addr_left_r != 3'd0) begin
                  addr_left_nxt = al_m1;
                  phase_nxt     = i2cms_pkg::PH_WADDR;
                  push.res0     = i2cms_pkg::mk_res(i2cms_pkg::CMD_SEND, addr_byte, 1'b0,
                                                    8'd0, 1'b0, i2cms_pkg::ERR_NONE, 1'b1);
                end else if (read_mode_r) begin
                  phase_nxt  = i2cms_pkg::PH_RSTART;
                  push.count = 2'd2;
                  push.res0  = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 8'd0,
                                                 1'b0, i2cms_pkg::ERR_NONE, 1'b0);
                  push.res1  = i2cms_pkg::mk_res(i2cms_pkg::CMD_START, 8'd0, 1'b0, 8'd0,
                                                 1'b0, i2cms_pkg::ERR_NONE, 1'b1);
                end else if (bytes_left_r != 8'd0) begin
                  bptr_nxt       = bptr_r + 8'd1;
                  bytes_left_nxt = bytes_left_r - 8'd1;
                  phase_nxt      = i2cms_pkg::PH_WDATA;
                  push.res0      = i2cms_pkg::mk_res(i2cms_pkg::CMD_SEND, mem_rd_data, 1'b0,
                                                     8'd0, 1'b0, i2cms_pkg::ERR_NONE, 1'b1);
                end else begin
                  phase_nxt = i2cms_pkg::PH_IDLE;
                  push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 8'd0,
                                                1'b1, i2cms_pkg::ERR_NONE, 1'b1);
                end
              end else if ((phase_r == i2cms_pkg::PH_WSLA) ?
                           i2cms_pkg::status_is(s, i2cms_pkg::ST_SLAW_NACK) :
                           i2cms_pkg::status_is(s, i2cms_pkg::ST_DATA_NACK)) begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_NACK, 1'b1);
              end else if (i2cms_pkg::status_is(s, i2cms_pkg::ST_ARB_LOST)) begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_RELEASE, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_BUS, 1'b1);
              end else begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_BUS, 1'b1);
              end
            end
            i2cms_pkg::PH_RSLA: begin
              if (i2cms_pkg::status_is(s, i2cms_pkg::ST_SLAR_ACK)) begin
                if (bytes_left_r == 8'd0) begin
                  phase_nxt = i2cms_pkg::PH_IDLE;
                  push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 8'd0,
                                                1'b1, i2cms_pkg::ERR_NONE, 1'b1);
                end else begin
                  phase_nxt = i2cms_pkg::PH_RDATA;
                  push.res0 = i2cms_pkg::mk_res((bytes_left_r == 8'd1) ?
                                                i2cms_pkg::CMD_RXNACK : i2cms_pkg::CMD_RXACK,
                                                8'd0, 1'b0, 8'd0, 1'b0,
                                                i2cms_pkg::ERR_NONE, 1'b1);
                end
              end else if (i2cms_pkg::status_is(s, i2cms_pkg::ST_SLAR_NACK)) begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_NACK, 1'b1);
              end else if (i2cms_pkg::status_is(s, i2cms_pkg::ST_ARB_LOST)) begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_RELEASE, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_BUS, 1'b1);
              end else begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_BUS, 1'b1);
              end
            end
            i2cms_pkg::PH_RDATA: begin
              if (i2cms_pkg::status_is(s, i2cms_pkg::ST_RCV_ACK) ||
                  i2cms_pkg::status_is(s, i2cms_pkg::ST_RCV_NACK)) begin
                // A received byte rides along with the next command.
                bytes_left_nxt = bl_dec;
                if (i2cms_pkg::status_is(s, i2cms_pkg::ST_RCV_NACK) || bl_dec == 8'd0) begin
                  phase_nxt = i2cms_pkg::PH_IDLE;
                  push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b1,
                                                item_r.bus_data, 1'b1,
                                                i2cms_pkg::ERR_NONE, 1'b1);
                end else begin
                  phase_nxt = i2cms_pkg::PH_RDATA;
                  push.res0 = i2cms_pkg::mk_res((bl_dec == 8'd1) ?
                                                i2cms_pkg::CMD_RXNACK : i2cms_pkg::CMD_RXACK,
                                                8'd0, 1'b1, item_r.bus_data, 1'b0,
                                                i2cms_pkg::ERR_NONE, 1'b1);
                end
              end else if (i2cms_pkg::status_is(s, i2cms_pkg::ST_ARB_LOST)) begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_RELEASE, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_BUS, 1'b1);
              end else begin
                phase_nxt = i2cms_pkg::PH_IDLE;
                push.res0 = i2cms_pkg::mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 8'd0,
                                              1'b1, i2cms_pkg::ERR_BUS, 1'b1);
              end
            end
            default: begin
              push.count = 2'd0;
            end
          endcase
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cms_pkg::PH_IDLE;
      read_mode_r  <= 1'b0;
      target_r     <= 7'd0;
      reg_addr_r   <= 32'd0;
      addr_left_r  <= 3'd0;
      bytes_left_r <= 8'd0;
      bptr_r       <= 8'd0;
    end else begin
      phase_r      <= phase_nxt;
      read_mode_r  <= read_mode_nxt;
      target_r     <= target_nxt;
      reg_addr_r   <= reg_addr_nxt;
      addr_left_r  <= addr_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      bptr_r       <= bptr_nxt;
    end
  end

endmodule

// ===== design/i2cms_out_queue.sv =====
module i2cms_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  i2cms_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cms_pkg::res_t  out_res
);

  localparam int DEPTH = i2cms_pkg::OUTQ_DEPTH;
  localparam int PW    = i2cms_pkg::OUTQ_PW;
  localparam int CW    = i2cms_pkg::OUTQ_CW;

  i2cms_pkg::res_t q_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = q_r[rp_r];
  // Room for the two results that one item may produce.
  assign room      = (cnt_r <= CW'(DEPTH - 2));

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[wp_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      q_r[wp_r + PW'(1)] <= push.res1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PW'(push.count);
      rp_r  <= rp_r + PW'(pop);
      cnt_r <= cnt_r + CW'(push.count) - CW'(pop);
    end
  end

endmodule

// ===== bench/i2c_master_transaction_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_core_tb;
  import i2cms_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 600;

  typedef struct {
    in_item_t it;
    bit       drain;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  i2c_master_transaction_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // Stimulus and expected bus commands.
  stim_t    pending_items[$];
  res_t     expected_cmds[$];
  in_item_t cur_item;
  bit       item_taken = 0;
  bit       drain_next = 0;
  bit       slot_loaded [256];
  int       item_total = 0;
  int       mismatches = 0;
  int       results_seen = 0;
  int unsigned cyc = 0;

  // Shadow of the sequencer state.
  phase_t      ph = PH_IDLE;
  logic        rd_mode = 1'b0;
  logic [6:0]  tgt_addr = '0;
  logic [31:0] reg_addr = '0;
  logic [2:0]  addr_left = '0;
  logic [7:0]  bytes_left = '0;
  logic [7:0]  buf_ptr = '0;
  logic [7:0]  payload_mirror [256];

  function automatic res_t bus_result(cmd_t c, logic [7:0] tx, logic rxv, logic [7:0] rx,
                                      logic done, logic [1:0] err, logic lst);
    res_t r;
    r.command    = c;
    r.tx_byte    = tx;
    r.rx_valid   = rxv;
    r.rx_byte    = rx;
    r.done_res   = done;
    r.error_code = err;
    r.last       = lst;
    return r;
  endfunction

  function automatic logic [87:0] pack_item(in_item_t it);
    return {6'b0, it.bus_data, it.bus_status, it.byte_count, it.address_bytes,
            it.internal_address, it.device_address, it.payload_byte, it.payload_index};
  endfunction

  // Ends the transaction with one final command.
  task automatic finish_transfer(cmd_t c, logic rxv, logic [7:0] rx, logic [1:0] err);
    ph = PH_IDLE;
    expected_cmds.push_back(bus_result(c, 8'h00, rxv, rx, 1'b1, err, 1'b1));
  endtask

  task automatic request_receive(logic rxv, logic [7:0] rx);
    ph = PH_RDATA;
    expected_cmds.push_back(bus_result(bytes_left == 8'd1 ? CMD_RXNACK : CMD_RXACK,
                                       8'h00, rxv, rx, 1'b0, ERR_NONE, 1'b1));
  endtask

  // Next step once SLA+W, a register address byte or a payload byte has been acknowledged.
  task automatic write_acked();
    logic [2:0] k;
    logic [7:0] b;
    if (addr_left != 3'd0) begin
      k = addr_left - 3'd1;
      b = reg_addr[8 * k[1:0] +: 8];
      addr_left = addr_left - 3'd1;
      ph = PH_WADDR;
      expected_cmds.push_back(bus_result(CMD_SEND, b, 1'b0, 8'h00, 1'b0, ERR_NONE, 1'b1));
    end else if (rd_mode) begin
      ph = PH_RSTART;
      expected_cmds.push_back(bus_result(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, ERR_NONE, 1'b0));
      expected_cmds.push_back(bus_result(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, ERR_NONE, 1'b1));
    end else if (bytes_left != 8'd0) begin
      b = payload_mirror[buf_ptr];
      buf_ptr = buf_ptr + 8'd1;
      bytes_left = bytes_left - 8'd1;
      ph = PH_WDATA;
      expected_cmds.push_back(bus_result(CMD_SEND, b, 1'b0, 8'h00, 1'b0, ERR_NONE, 1'b1));
    end else begin
      finish_transfer(CMD_STOP, 1'b0, 8'h00, ERR_NONE);
    end
  endtask

  // Reaction to a bus status while a transaction is running.
  task automatic status_step(logic [7:0] s, logic [7:0] data);
    logic [7:0] ack;
    logic [7:0] nack;
    case (ph)
      PH_WSTART, PH_RSTART: begin
        if (s == ST_START || s == ST_RSTART) begin
          expected_cmds.push_back(bus_result(CMD_SEND, {tgt_addr, ph == PH_RSTART}, 1'b0,
                                             8'h00, 1'b0, ERR_NONE, 1'b1));
          ph = (ph == PH_RSTART) ? PH_RSLA : PH_WSLA;
        end else begin
          finish_transfer(CMD_NONE, 1'b0, 8'h00, ERR_BUS);
        end
      end
      PH_WSLA, PH_WADDR, PH_WDATA: begin
        ack  = (ph == PH_WSLA) ? ST_SLAW_ACK : ST_DATA_ACK;
        nack = (ph == PH_WSLA) ? ST_SLAW_NACK : ST_DATA_NACK;
        if (s == ack) write_acked();
        else if (s == nack) finish_transfer(CMD_STOP, 1'b0, 8'h00, ERR_NACK);
        else if (s == ST_ARB_LOST) finish_transfer(CMD_RELEASE, 1'b0, 8'h00, ERR_BUS);
        else finish_transfer(CMD_STOP, 1'b0, 8'h00, ERR_BUS);
      end
      PH_RSLA: begin
        if (s == ST_SLAR_ACK) begin
          if (bytes_left == 8'd0) finish_transfer(CMD_STOP, 1'b0, 8'h00, ERR_NONE);
          else request_receive(1'b0, 8'h00);
        end else if (s == ST_SLAR_NACK) begin
          finish_transfer(CMD_STOP, 1'b0, 8'h00, ERR_NACK);
        end else if (s == ST_ARB_LOST) begin
          finish_transfer(CMD_RELEASE, 1'b0, 8'h00, ERR_BUS);
        end else begin
          finish_transfer(CMD_STOP, 1'b0, 8'h00, ERR_BUS);
        end
      end
      PH_RDATA: begin
        if (s == ST_RCV_ACK || s == ST_RCV_NACK) begin
          if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
          if (s == ST_RCV_NACK || bytes_left == 8'd0) finish_transfer(CMD_STOP, 1'b1, data, ERR_NONE);
          else request_receive(1'b1, data);
        end else if (s == ST_ARB_LOST) begin
          finish_transfer(CMD_RELEASE, 1'b0, 8'h00, ERR_BUS);
        end else begin
          finish_transfer(CMD_STOP, 1'b0, 8'h00, ERR_BUS);
        end
      end
      default: ;
    endcase
  endtask

  // Works out the bus commands caused by one accepted transaction.
  task automatic predict_bus_commands(in_item_t it);
    logic [2:0] nab;
    case (it.opcode)
      OP_LOAD: payload_mirror[it.payload_index] = it.payload_byte;
      OP_STATUS: if (ph != PH_IDLE) status_step(it.bus_status & ST_MASK, it.bus_data);
      default: begin
        if (ph == PH_IDLE) begin
          nab = (it.address_bytes > 3'd4) ? 3'd4 : it.address_bytes;
          rd_mode    = (it.opcode == OP_READ);
          tgt_addr   = it.device_address;
          reg_addr   = it.internal_address;
          addr_left  = nab;
          bytes_left = it.byte_count;
          buf_ptr    = 8'd0;
          ph = (rd_mode && nab == 3'd0) ? PH_RSTART : PH_WSTART;
          expected_cmds.push_back(bus_result(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, ERR_NONE, 1'b1));
        end
      end
    endcase
  endtask

  // Stimulus building.
  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode           = opcode_t'($urandom_range(0, 3));
    it.payload_index    = 8'($urandom_range(0, 255));
    it.payload_byte     = 8'($urandom_range(0, 255));
    it.device_address   = 7'($urandom_range(0, 127));
    it.internal_address = $urandom();
    it.address_bytes    = 3'($urandom_range(0, 7));
    it.byte_count       = 8'($urandom_range(0, 255));
    it.bus_status       = 8'($urandom_range(0, 255));
    it.bus_data         = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic push_item(in_item_t it, bit counted);
    stim_t st;
    st.it = it;
    st.drain = drain_next;
    drain_next = 0;
    pending_items.push_back(st);
    if (counted) item_total++;
  endtask

  task automatic add_load(logic [7:0] idx, logic [7:0] b);
    in_item_t it;
    it = random_item();
    it.opcode = OP_LOAD;
    it.payload_index = idx;
    it.payload_byte = b;
    slot_loaded[idx] = 1'b1;
    push_item(it, 1);
  endtask

  // A write only ever sends payload slots that have been loaded.
  task automatic ensure_loaded(int n);
    for (int i = 0; i < n; i++)
      if (!slot_loaded[i]) add_load(8'(i), 8'($urandom_range(0, 255)));
  endtask

  task automatic add_begin(opcode_t op, logic [6:0] dev, logic [31:0] addr,
                           logic [2:0] nab, logic [7:0] n);
    in_item_t it;
    it = random_item();
    if (op == OP_WRITE) ensure_loaded(int'(n));
    it.opcode = op;
    it.device_address = dev;
    it.internal_address = addr;
    it.address_bytes = nab;
    it.byte_count = n;
    push_item(it, 1);
  endtask

  task automatic add_status(logic [7:0] s);
    in_item_t it;
    it = random_item();
    it.opcode = OP_STATUS;
    it.bus_status = s | 8'($urandom_range(0, 7));
    push_item(it, 1);
  endtask

  // Stray item: any opcode, a begin may be ignored or start an unplanned transfer.
  task automatic add_noise();
    in_item_t it;
    it = random_item();
    if (it.opcode == OP_WRITE) begin
      it.byte_count = 8'($urandom_range(0, 7));
      ensure_loaded(int'(it.byte_count));
    end
    if (it.opcode == OP_LOAD) slot_loaded[it.payload_index] = 1'b1;
    push_item(it, 0);
  endtask

  function automatic logic [7:0] bad_status();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return ST_SLAW_NACK;
      2: return ST_DATA_NACK;
      3: return ST_ARB_LOST;
      4: return ST_SLAR_NACK;
      5: return ST_RCV_NACK;
      6: return ST_MASK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One well-formed transaction with random content, sometimes broken off by a bad status.
  task automatic gen_transaction();
    logic [7:0] plan[$];
    bit         is_read;
    int         n;
    int         nab;
    int         k;
    logic [2:0] nab_field;
    is_read = 1'($urandom_range(0, 1));
    n = ($urandom_range(0, 59) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 5);
    nab_field = 3'($urandom_range(0, 7));
    nab = (nab_field > 3'd4) ? 4 : nab_field;
    plan.push_back($urandom_range(0, 1) ? ST_START : ST_RSTART);
    if (!is_read || nab > 0) begin
      plan.push_back(ST_SLAW_ACK);
      repeat (nab) plan.push_back(ST_DATA_ACK);
    end
    if (!is_read) begin
      repeat (n + 1) plan.push_back(ST_DATA_ACK);
    end else begin
      if (nab > 0) plan.push_back($urandom_range(0, 1) ? ST_START : ST_RSTART);
      plan.push_back(ST_SLAR_ACK);
      if (n > 0) begin
        repeat (n - 1) plan.push_back(ST_RCV_ACK);
        plan.push_back($urandom_range(0, 1) ? ST_RCV_NACK : ST_RCV_ACK);
      end
    end
    if ($urandom_range(0, 9) < 3) begin
      k = $urandom_range(0, plan.size() - 1);
      plan[k] = bad_status();
      while (plan.size() > k + 1) void'(plan.pop_back());
    end
    add_begin(is_read ? OP_READ : OP_WRITE, 7'($urandom_range(0, 127)), $urandom(),
              nab_field, 8'(n));
    foreach (plan[i]) begin
      if ($urandom_range(0, 19) == 0) add_noise();
      add_status(plan[i]);
    end
  endtask

  function automatic int idle_len();
    return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(12, 40);
  endfunction

  // Sender: offers queued transactions at the falling edge.
  int send_gap = 0;
  always @(negedge clk) begin : sender
    logic nv;
    if (rst_n) begin
      nv = in_tvalid;
      if (item_taken) begin
        item_taken = 0;
        nv = 1'b0;
        send_gap = (cyc[8:7] == 2'b11 || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_cmds.size() != 0)) begin
          cur_item = pending_items[0].it;
          void'(pending_items.pop_front());
          in_tdata <= pack_item(cur_item);
          in_tuser <= cur_item.opcode;
          nv = 1'b1;
        end
      end
      in_tvalid <= nv;
    end
  end

  // Receiver: random stalls, and one long hold-off that fills the block.
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(negedge clk) begin : receiver
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 300) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (cyc[9:8] != 2'b10 && $urandom_range(0, 3) == 0) recv_gap = idle_len();
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Acceptance on the input side and result checking on the output side.
  always @(posedge clk) begin : monitor
    res_t e;
    cyc++;
    if (rst_n && in_tvalid && in_tready) begin
      predict_bus_commands(cur_item);
      item_taken = 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result: expected none, got command %0d data %h last %b",
                 $time, out_tuser, out_tdata, out_tlast);
        mismatches++;
      end else begin
        e = expected_cmds.pop_front();
        check_field("command", e.command, out_tuser);
        check_field("tx_byte", e.tx_byte, out_tdata[7:0]);
        check_field("rx_valid", e.rx_valid, out_tdata[8]);
        check_field("rx_byte", e.rx_byte, out_tdata[16:9]);
        check_field("done_res", e.done_res, out_tdata[17]);
        check_field("error_code", e.error_code, out_tdata[19:18]);
        check_field("last", e.last, out_tlast);
      end
    end
  end

  // Watchdog: too long without any transaction moving on either side.
  int stall_cnt = 0;
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_cmds.size());
        $display("** i2c_master_transaction_sequencer_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int tx_no;
    tx_no = 0;

    // Directed part: idle status, buffer extremes, saturated address length,
    // begin while busy, zero-length read, read with a repeated start, and
    // early endings by an unconfirmed start and by arbitration loss.
    add_status(ST_SLAW_ACK);
    add_load(8'hFF, 8'hFF);
    add_load(8'h00, 8'h00);
    add_load(8'h01, 8'hFF);
    add_begin(OP_WRITE, 7'h7F, 32'hA1B2_C3D4, 3'd7, 8'd2);
    add_status(ST_START);
    add_begin(OP_READ, 7'h00, 32'h0, 3'd0, 8'd1);
    add_status(ST_SLAW_ACK);
    repeat (4) add_status(ST_DATA_ACK);
    repeat (3) add_status(ST_DATA_ACK);
    add_begin(OP_READ, 7'h00, 32'hFFFF_FFFF, 3'd0, 8'd0);
    add_status(ST_RSTART);
    add_status(ST_SLAR_ACK);
    add_begin(OP_READ, 7'h55, 32'h0000_005A, 3'd1, 8'd2);
    add_status(ST_START);
    add_status(ST_SLAW_ACK);
    add_status(ST_DATA_ACK);
    add_status(ST_RSTART);
    add_status(ST_SLAR_ACK);
    add_status(ST_RCV_ACK);
    add_status(ST_RCV_NACK);
    add_begin(OP_WRITE, 7'h2A, 32'h0, 3'd0, 8'd0);
    add_status(8'h00);
    add_begin(OP_WRITE, 7'h15, 32'h0, 3'd0, 8'd1);
    add_status(ST_START);
    add_status(ST_ARB_LOST);

    // Random part, with a pause for the results to drain now and then.
    while (item_total < ITEM_TARGET) begin
      tx_no++;
      if (tx_no % 45 == 0) drain_next = 1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) add_noise();
      else gen_transaction();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("** i2c_master_transaction_sequencer_core: PASSED **");
    end else begin
      $display("** i2c_master_transaction_sequencer_core: FAILED **");
    end
    $finish;
  end

endmodule
